// ===== rtl/core/r2a_pkg.sv =====
`timescale 1ns / 1ps

package r2a_pkg;

   // Default width of the converted number, sign bit included.
   localparam int NUM_BITS_DEF = 32;

   // Fixed field widths.
   localparam int RADIX_W  = 5;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int DIGIT_W  = 4;

   // Quotient bits resolved per divider cycle.
   localparam int DIV_BITS_PER_CYCLE = 4;

   // Base limits and the bases that carry a prefix.
   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

   // Status codes on the result channel.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_RADIX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 2'd2;

   // ASCII characters used outside the digit table.
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_A_OFFSET = 8'h57;

   // Source of the character loaded into the result register.
   typedef enum logic [1:0] {
      CH_ZERO,
      CH_X,
      CH_DIGIT,
      CH_ERR
   } char_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         in_ready;
      logic         div_step;
      logic         digit_wr;
      logic         rd_en;
      logic         idx_dec;
      logic         out_load;
      char_sel_type out_sel;
      logic         out_last;
   } r2a_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_fire;
      logic out_free;
      logic bad_radix;
      logic negative;
      logic radix_hex;
      logic radix_oct;
      logic work_zero;
      logic idx_zero;
   } r2a_stat_type;

   // Lower-case ASCII for one digit value.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = CHAR_W'(d);
      if (d < 4'd10) begin
         return CHAR_ZERO + ext;
      end
      return CHAR_A_OFFSET + ext;
   endfunction

endpackage

// ===== rtl/core/r2a_if.sv =====
`timescale 1ns / 1ps

// Input channel: one beat carries a number and a requested base.
interface r2a_req_if #(
   parameter int NUM_BITS = r2a_pkg::NUM_BITS_DEF
);
   logic                               valid;
   logic                               ready;
   logic signed [NUM_BITS-1:0]         number;
   logic [r2a_pkg::RADIX_W-1:0]        radix;

   modport source (output valid, output number, output radix, input ready);
   modport sink   (input valid, input number, input radix, output ready);
endinterface

// Result channel: one beat carries one character of the conversion.
interface r2a_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [r2a_pkg::CHAR_W-1:0]         character;
   logic [r2a_pkg::STATUS_W-1:0]       status;
   logic                               last;

   modport source (output valid, output character, output status, output last, input ready);
   modport sink   (input valid, input character, input status, input last, output ready);
endinterface

// ===== rtl/core/r2a_ram.sv =====
`timescale 1ns / 1ps

module r2a_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/r2a_datapath.sv =====
`timescale 1ns / 1ps

module r2a_datapath #(
   parameter int NUM_BITS = r2a_pkg::NUM_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   r2a_req_if.sink               req_if,
   r2a_rsp_if.source             rsp_if,
   input  r2a_pkg::r2a_cmd_type  cmd,
   output r2a_pkg::r2a_stat_type stat
);
   import r2a_pkg::*;

   localparam int MAG_W   = NUM_BITS - 1;
   localparam int STEPS   = (MAG_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
   localparam int DIV_W   = STEPS * DIV_BITS_PER_CYCLE;
   localparam int DEPTH   = NUM_BITS;
   localparam int CNT_W   = $clog2(DEPTH);

   logic [DIV_W-1:0]    work_ff, work_in;
   logic [RADIX_W-1:0]  radix_ff, radix_in;
   logic                neg_ff, neg_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;

   logic [DIV_W-1:0]    step_work;
   logic [DIGIT_W:0]    step_rem;
   logic [DIGIT_W-1:0]  ram_q;
   logic                req_fire;
   logic                bad_radix;
   logic [STATUS_W-1:0] err_code;

   assign req_if.ready = cmd.in_ready;
   assign req_fire     = req_if.valid & cmd.in_ready;

   // Base and sign checks on the captured item.
   assign bad_radix = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);
   assign err_code  = bad_radix ? ST_BAD_RADIX : ST_NEGATIVE;

   // One divider cycle: restoring division, several quotient bits per cycle.
   // Quotient bits shift in at the bottom of the dividend register.
   always_comb begin
      step_work = work_ff;
      step_rem  = {1'b0, rem_ff};
      for (int j = 0; j < DIV_BITS_PER_CYCLE; j++) begin
         step_rem  = {step_rem[DIGIT_W-1:0], step_work[DIV_W-1]};
         step_work = {step_work[DIV_W-2:0], 1'b0};
         if (step_rem >= radix_ff) begin
            step_rem     = step_rem - radix_ff;
            step_work[0] = 1'b1;
         end
      end
   end

   // Digit store, least significant digit at index zero.
   r2a_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DEPTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (cmd.digit_wr),
      .wr_addr (count_ff),
      .wr_data (rem_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_q)
   );

   // Working registers: capture, division, digit count and read pointer.
   always_comb begin
      work_in   = work_ff;
      radix_in  = radix_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      if (req_fire) begin
         work_in  = DIV_W'(req_if.number[MAG_W-1:0]);
         radix_in = req_if.radix;
         neg_in   = req_if.number[NUM_BITS-1];
         rem_in   = '0;
         count_in = '0;
      end else if (cmd.div_step) begin
         work_in = step_work;
         rem_in  = step_rem[DIGIT_W-1:0];
      end else if (cmd.digit_wr) begin
         rem_in    = '0;
         count_in  = count_ff + 1'b1;
         rd_idx_in = count_ff;
      end else if (cmd.idx_dec) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   // Result register: loaded on command, cleared when its beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         last_in      = cmd.out_last;
         case (cmd.out_sel)
            CH_ZERO:  char_in = CHAR_ZERO;
            CH_X:     char_in = CHAR_X;
            CH_DIGIT: char_in = digit_char(ram_q);
            CH_ERR: begin
               char_in   = CHAR_NUL;
               status_in = err_code;
            end
            default:  char_in = CHAR_NUL;
         endcase
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff   <= work_in;
      radix_ff  <= radix_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      char_ff   <= char_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.character = char_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.last      = last_ff;

   // Status back to the controller.
   always_comb begin
      stat.req_fire  = req_fire;
      stat.out_free  = !rsp_valid_ff || rsp_if.ready;
      stat.bad_radix = bad_radix;
      stat.negative  = neg_ff;
      stat.radix_hex = (radix_ff == RADIX_HEX);
      stat.radix_oct = (radix_ff == RADIX_OCT);
      stat.work_zero = (work_ff == '0);
      stat.idx_zero  = (rd_idx_ff == '0);
   end

endmodule

// ===== rtl/core/r2a_ctrl.sv =====
`timescale 1ns / 1ps

module r2a_ctrl #(
   parameter int NUM_BITS = r2a_pkg::NUM_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  r2a_pkg::r2a_stat_type stat,
   output r2a_pkg::r2a_cmd_type  cmd
);
   import r2a_pkg::*;

   localparam int MAG_W = NUM_BITS - 1;
   localparam int STEPS = (MAG_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
   localparam int SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [SC_W-1:0] STEP_LAST = SC_W'(STEPS - 1);

   typedef enum logic [3:0] {
      IDLE,
      CHECK,
      ERROR,
      PFX_ZERO,
      PFX_X,
      DIV_RUN,
      DIGIT_WR,
      EMIT_RD,
      EMIT_OUT
   } state_type;

   state_type       state_ff, state_in;
   logic [SC_W-1:0] step_ff, step_in;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = '0;
      cmd          = '0;
      cmd.out_sel  = CH_ERR;
      case (state_ff)
         IDLE: begin
            cmd.in_ready = 1'b1;
            if (stat.req_fire) begin
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (stat.bad_radix || stat.negative) begin
               state_in = ERROR;
            end else if (stat.radix_hex || (stat.radix_oct && !stat.work_zero)) begin
               state_in = PFX_ZERO;
            end else begin
               state_in = DIV_RUN;
            end
         end
         ERROR: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = CH_ERR;
               cmd.out_last = 1'b1;
               state_in     = IDLE;
            end
         end
         PFX_ZERO: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = CH_ZERO;
               state_in     = stat.radix_hex ? PFX_X : DIV_RUN;
            end
         end
         PFX_X: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = CH_X;
               state_in     = DIV_RUN;
            end
         end
         DIV_RUN: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = DIGIT_WR;
            end
         end
         DIGIT_WR: begin
            cmd.digit_wr = 1'b1;
            state_in     = stat.work_zero ? EMIT_RD : DIV_RUN;
         end
         EMIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = EMIT_OUT;
         end
         EMIT_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = CH_DIGIT;
               cmd.out_last = stat.idx_zero;
               if (stat.idx_zero) begin
                  state_in = IDLE;
               end else begin
                  cmd.idx_dec = 1'b1;
                  state_in    = EMIT_RD;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== rtl/core/radix_integer_to_ascii_top.sv =====
// Sequence: the input beat is checked; an invalid item gives one error character, a valid one
// gives any prefix characters, then its digits, found by division and held in the digit store,
// and sent most significant first.
// Throughput: one item at a time; each further digit is read from the digit store, then loaded
// into the result register.
// Reset is synchronous, active high, and returns the controller to idle.
`timescale 1ns / 1ps

module radix_integer_to_ascii_top #(
   parameter int NUM_BITS = r2a_pkg::NUM_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   r2a_req_if.sink   req_if,
   r2a_rsp_if.source rsp_if
);
   import r2a_pkg::*;

   r2a_cmd_type  cmd;
   r2a_stat_type stat;

   // Sequencing of checks, prefix, division and digit output.
   r2a_ctrl #(
      .NUM_BITS (NUM_BITS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Divider, digit store and result register.
   r2a_datapath #(
      .NUM_BITS (NUM_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .stat   (stat)
   );

endmodule
